/* hw/rtl/kwm_pkg.sv */
// Shared types and codes for the k-way sorted merge block.
package kwm_pkg;

	typedef enum logic [2:0] {
		ST_APPENDED   = 3'd0,
		ST_FULL       = 3'd1,
		ST_OUT_OF_USE = 3'd2,
		ST_TAKEN      = 3'd3,
		ST_EMPTY      = 3'd4
	} status_t;

	typedef enum logic {
		KIND_APPEND = 1'b0,
		KIND_TAKE   = 1'b1
	} kind_t;

	typedef enum logic {
		B_RUN,
		B_REFILL
	} back_state_t;

	localparam logic [1:0] REG_LISTS_IN_USE = 2'd0;

	typedef struct packed {
		logic               kind;
		logic [2:0]         list_number;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] taken_value;
		logic [2:0]         source_list;
	} res_t;

	typedef struct packed {
		logic               is_take;
		logic               out_of_use;
		logic [2:0]         list_number;
		logic signed [31:0] value;
	} cmd_t;

endpackage

/* hw/rtl/kwm_ram.sv */
// Generic simple dual-port RAM with registered read.
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hw/rtl/kwm_front.sv */
// Front end: accept requests, classify them and queue the commands.
module kwm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  kwm_pkg::req_t  req,
	input  logic [3:0]     lists_in_use,
	input  logic [6:0]     lists_total,
	output logic           cmd_valid,
	output kwm_pkg::cmd_t  cmd,
	input  logic           cmd_pop
);
	import kwm_pkg::*;

	cmd_t       qmem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cls;

	assign req_stall = (cnt_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = qmem_q[rd_q];

	always_comb begin
		cls.is_take     = (req.kind == KIND_TAKE);
		cls.out_of_use  = ({1'b0, req.list_number} >= lists_in_use) ||
			({4'b0, req.list_number} >= lists_total);
		cls.list_number = req.list_number;
		cls.value       = req.value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qmem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("command queue count out of range");
`endif
endmodule

/* hw/rtl/kwm_back.sv */
// Back end: carry out appends and takes over the list store.
module kwm_back #(
	parameter int LISTS = 8,
	parameter int DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  kwm_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	input  logic [3:0]     lists_in_use,
	output logic           res_valid,
	input  logic           res_stall,
	output kwm_pkg::res_t  res
);
	import kwm_pkg::*;

	localparam int LW = $clog2(LISTS);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(LISTS * DEPTH);

	back_state_t        state_q, state_d;
	logic [PW-1:0]      head_q [LISTS];
	logic [PW-1:0]      tail_q [LISTS];
	logic [CW-1:0]      cnt_q  [LISTS];
	logic signed [31:0] hval_q [LISTS];
	logic [LW-1:0]      refill_q;
	logic               res_valid_q;
	res_t               res_q;

	logic               exec;
	logic [LW-1:0]      li;
	logic               found;
	logic [LW-1:0]      best;
	logic signed [31:0] best_val;
	logic               do_append;
	logic               do_take;
	logic               need_refill;
	logic [PW-1:0]      new_head;
	logic [PW-1:0]      new_tail;
	res_t               res_d;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;

	assign li      = LW'(cmd.list_number);
	assign exec    = cmd_valid && (state_q == B_RUN) && (!res_valid_q || !res_stall);
	assign cmd_pop = exec;

	// Smallest cached head among non-empty lists in use; lowest list wins ties.
	always_comb begin
		found    = 1'b0;
		best     = '0;
		best_val = '0;
		for (int i = 0; i < LISTS; i++) begin
			if (cnt_q[i] != '0 && 32'(i) < 32'(lists_in_use)) begin
				if (!found || hval_q[i] < best_val) begin
					found    = 1'b1;
					best     = LW'(i);
					best_val = hval_q[i];
				end
			end
		end
	end

	always_comb begin
		do_append   = 1'b0;
		do_take     = 1'b0;
		res_d       = '{status: ST_APPENDED, taken_value: '0, source_list: '0};
		if (!cmd.is_take) begin
			priority if (cmd.out_of_use) begin
				res_d.status = ST_OUT_OF_USE;
			end else if (cnt_q[li] == CW'(DEPTH)) begin
				res_d.status = ST_FULL;
			end else begin
				do_append = exec;
			end
		end else if (!found) begin
			res_d.status = ST_EMPTY;
		end else begin
			do_take           = exec;
			res_d.status      = ST_TAKEN;
			res_d.taken_value = best_val;
			res_d.source_list = 3'(best);
		end
		new_head    = (head_q[best] == PW'(DEPTH - 1)) ? '0 : head_q[best] + 1'b1;
		new_tail    = (tail_q[li] == PW'(DEPTH - 1)) ? '0 : tail_q[li] + 1'b1;
		need_refill = do_take && (cnt_q[best] > CW'(1));
		ram_we      = do_append;
		ram_waddr   = AW'(32'(li) * DEPTH + 32'(tail_q[li]));
		ram_re      = need_refill;
		ram_raddr   = AW'(32'(best) * DEPTH + 32'(new_head));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_RUN: begin
				if (need_refill) begin
					state_d = B_REFILL;
				end
			end
			B_REFILL: begin
				state_d = B_RUN;
			end
			default: state_d = B_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			res_valid_q <= 1'b0;
		end else begin
			if (do_append) begin
				tail_q[li] <= new_tail;
				cnt_q[li]  <= cnt_q[li] + 1'b1;
			end
			if (do_take) begin
				head_q[best] <= new_head;
				cnt_q[best]  <= cnt_q[best] - 1'b1;
			end
			if (exec) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Head cache: appends to an empty list fill it; takes leaving entries refill from RAM.
	always_ff @(posedge clk) begin
		if (do_append && cnt_q[li] == '0) begin
			hval_q[li] <= cmd.value;
		end
		if (state_q == B_REFILL) begin
			hval_q[refill_q] <= ram_rdata;
		end
		if (need_refill) begin
			refill_q <= best;
		end
		if (exec) begin
			res_q <= res_d;
		end
	end

	kwm_ram #(.WIDTH(32), .DEPTH(LISTS * DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_refill_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_REFILL |=> state_q == B_RUN) else $error("refill lasted too long");
	a_no_exec_refill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_REFILL |-> !cmd_pop) else $error("command run during refill");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty queue");
`endif
endmodule

/* hw/rtl/k_way_sorted_merge.sv */
// Top level of the k-way sorted merge: register port, front end and back end.
// Path: an accepted request is registered in the front end's command queue, and its result
//   is registered in the back end before it is presented.
// A take that leaves its list non-empty holds off the next command while the new head
//   of the chosen list is read through the store's read port into the head cache; any
//   command also waits while the previous result is held by res_stall.
// Reset clears head, tail and fill counts and sets lists_in_use to 8; the element store
//   is left as it is and needs no clearing pass, since only written entries are read.
module k_way_sorted_merge #(
	parameter int LISTS = 8,
	parameter int DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  kwm_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_stall,
	output kwm_pkg::res_t  res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import kwm_pkg::*;

	logic [3:0] lists_q;
	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;
	logic       reg_hit;

	// Register file: one register, at byte addresses 0 to 3; 4 to 7 read as zero.
	assign pready  = 1'b1;
	assign reg_hit = ({1'b0, paddr[2]} == REG_LISTS_IN_USE);
	assign prdata  = reg_hit ? {28'b0, lists_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lists_q <= 4'd8;
		end else if (psel && penable && pwrite && reg_hit) begin
			lists_q <= pwdata[3:0];
		end
	end

	// Front end: classify each request and hold it in a two-entry queue.
	kwm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.lists_in_use (lists_q),
		.lists_total  (7'(LISTS)),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	// Back end: run the queued commands and hold each result until it is taken.
	kwm_back #(.LISTS(LISTS), .DEPTH(DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.lists_in_use (lists_q),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res)
	);
endmodule
